>>> hw/rtl/ogmc_pkg.sv
`timescale 1ns / 1ps

package ogmc_pkg;

  // Configuration field widths
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_DEC_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SCHEME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEVEL  = 3'd4;

  // Color schemes
  localparam logic [1:0] SCHEME_MAP     = 2'd0;
  localparam logic [1:0] SCHEME_COSTMAP = 2'd1;
  localparam logic [1:0] SCHEME_RAW     = 2'd2;

  localparam logic [7:0] ALPHA_RESET = 8'd179;

  // Grids wider or taller than this pool by at least two cells
  localparam int LARGE_GRID = 120;

  // Quotient of the block-row count is built one bit per step
  localparam int DIV_STEPS = CFG_SIZE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // floor(x / 100) == (x * 5243) >> 19 for every x the color ramp produces
  localparam logic [27:0] RECIP_100   = 28'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [7:0] UNKNOWN_R = 8'h70;
  localparam logic [7:0] UNKNOWN_G = 8'h89;
  localparam logic [7:0] UNKNOWN_B = 8'h86;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t colorize(input logic signed [7:0] p, input logic [1:0] scheme);
    rgb_t        c;
    logic [14:0] num;
    logic [27:0] prod;
    logic [7:0]  q;
    num = {p[6:0], 8'd0} - {8'd0, p[6:0]};
    if (scheme != SCHEME_COSTMAP) begin
      // round half up for the grey map
      num = num + 15'd50;
    end
    prod = {13'd0, num} * RECIP_100;
    q    = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    if (scheme == SCHEME_RAW) begin
      c = '{red: p, green: p, blue: p};
    end else if (p < 8'sd0) begin
      c = '{red: UNKNOWN_R, green: UNKNOWN_G, blue: UNKNOWN_B};
    end else if (p > 8'sd100) begin
      c = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
    end else if (scheme == SCHEME_COSTMAP) begin
      if (p == 8'sd0) begin
        c = '{red: 8'h00, green: 8'h00, blue: 8'h00};
      end else if (p == 8'sd99) begin
        c = '{red: 8'h00, green: 8'hFF, blue: 8'hFF};
      end else if (p == 8'sd100) begin
        c = '{red: 8'hFF, green: 8'h00, blue: 8'hFF};
      end else begin
        c = '{red: q, green: 8'h00, blue: 8'hFF - q};
      end
    end else begin
      c = '{red: 8'hFF - q, green: 8'hFF - q, blue: 8'hFF - q};
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/ogmc_ram.sv
`timescale 1ns / 1ps

module ogmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when both ports hit one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/occupancy_grid_maxpool_colorize.sv
`timescale 1ns / 1ps

// Occupancy grid max-pool downsampler with color mapping.
//
// Input stream: one signed occupancy cell per transfer, in raster order
// (row 0 first, each row from column 0 up). Output stream: one RGBA pixel
// per closed block of cells, tlast on the pixel of the frame's last cell.
// Configuration channel: index/data writes to grid size, decimation, color
// scheme and alpha; write it only while the stream is idle.
//
// Throughput is one cell per cycle unless the divider is busy or the output
// stalls, set by the single column-max RAM, read at accept and written as the
// cell leaves the pooling stage, with a one-entry bypass. A pixel leaves the
// pooling stage into the output register. After each configuration write a
// bit-serial divider recomputes the image height; in_tready is low meanwhile.
//
// Reset clears the counters, the pipeline and the registers to their
// defaults; the column RAM is not cleared (each block starts its own max).
// When the receiver stalls, the output register holds the result, the next
// block-closing cell waits in the pooling stage and in_tready drops after that.
module occupancy_grid_maxpool_colorize #(
  parameter int MAX_GRID_WIDTH  = 1024,
  parameter int MAX_GRID_HEIGHT = 1024,
  parameter int MAX_DECIMATION  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ogmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ogmc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // cell stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] cell_value
  // pixel stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [55:0]                       out_tdata,  // pixel_x, pixel_y, red, green,
                                                        // blue, alpha, zero pad
  output logic                              out_tlast   // last_pixel
);

  localparam int CW  = $clog2(MAX_GRID_WIDTH);
  localparam int RW  = $clog2(MAX_GRID_HEIGHT);
  localparam int OW  = $clog2(MAX_DECIMATION);
  localparam int DW  = $clog2(MAX_DECIMATION + 1);
  localparam int SW  = (DW > ogmc_pkg::CFG_DEC_W) ? DW : ogmc_pkg::CFG_DEC_W;
  localparam int MW0 = (CW > RW) ? CW : RW;
  localparam int EW  = ((MW0 > ogmc_pkg::CFG_SIZE_W) ? MW0 : ogmc_pkg::CFG_SIZE_W) + 1;
  localparam int QW  = ogmc_pkg::CFG_SIZE_W;

  typedef struct packed {
    logic signed [7:0] value;
    logic [CW-1:0]     idx;
    logic              first;
    logic              emit;
    logic              last;
    logic [9:0]        px;
    logic [9:0]        py;
  } s1_t;

  typedef struct packed {
    logic [9:0]      px;
    logic [9:0]      py;
    ogmc_pkg::rgb_t  rgb;
    logic [7:0]      alpha;
    logic            last;
  } pix_t;

  // configuration registers
  logic [ogmc_pkg::CFG_SIZE_W-1:0] grid_width_r, grid_height_r;
  logic [ogmc_pkg::CFG_DEC_W-1:0]  decimation_r;
  logic [1:0]                      color_scheme_r;
  logic [7:0]                      alpha_level_r;

  // raster counters
  logic [CW-1:0] cell_col_r, cell_col_nxt, blk_col_r, blk_col_nxt;
  logic [RW-1:0] cell_row_r, cell_row_nxt, blk_row_r, blk_row_nxt;
  logic [OW-1:0] off_x_r, off_x_nxt, off_y_r, off_y_nxt;

  // divider for image height - 1
  logic                 div_load_r;
  logic [ogmc_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [QW-1:0]        div_q_r;
  logic [SW-1:0]        div_rem_r;
  logic [SW:0]          div_trial;
  logic                 div_bit;
  logic                 div_busy;

  // pipeline
  logic              s1_valid_r;
  s1_t               s1_r, s1_nxt;
  logic              fwd_hit_r;
  logic signed [7:0] fwd_data_r;
  logic signed [7:0] ram_rdata, prev, pooled;
  logic              out_valid_r;
  pix_t              out_r;
  logic              s1_adv, in_accept, cfg_accept;

  // effective sizes
  logic [EW-1:0] wc, hc, hc_m1, py_full;
  logic [SW-1:0] sc;
  logic          big_grid;
  logic          row_end, end_x, end_y, last_cell, ox_end, oy_end, row_last;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign div_busy   = div_load_r || (div_cnt_r != '0);
  assign s1_adv     = s1_valid_r && (!s1_r.emit || !out_valid_r || out_tready);
  assign in_tready  = !div_busy && (!s1_valid_r || s1_adv);
  assign in_accept  = in_tvalid && in_tready;

  always_comb begin
    if (grid_width_r == '0) begin
      wc = EW'(1);
    end else if (EW'(grid_width_r) > EW'(MAX_GRID_WIDTH)) begin
      wc = EW'(MAX_GRID_WIDTH);
    end else begin
      wc = EW'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      hc = EW'(1);
    end else if (EW'(grid_height_r) > EW'(MAX_GRID_HEIGHT)) begin
      hc = EW'(MAX_GRID_HEIGHT);
    end else begin
      hc = EW'(grid_height_r);
    end
    big_grid = (wc > EW'(ogmc_pkg::LARGE_GRID)) || (hc > EW'(ogmc_pkg::LARGE_GRID));
    if (decimation_r == '0) begin
      sc = SW'(1);
    end else if (SW'(decimation_r) > SW'(MAX_DECIMATION)) begin
      sc = SW'(MAX_DECIMATION);
    end else begin
      sc = SW'(decimation_r);
    end
    if (big_grid && sc < SW'(2)) begin
      sc = SW'(2);
    end
  end

  assign hc_m1 = hc - EW'(1);

  // restoring division step
  assign div_trial = {div_rem_r, div_q_r[QW-1]};
  assign div_bit   = div_trial >= {1'b0, sc};

  // block closing decisions for the cell at the head of the stream
  always_comb begin
    ox_end    = EW'(off_x_r) + EW'(1) >= EW'(sc);
    oy_end    = EW'(off_y_r) + EW'(1) >= EW'(sc);
    row_end   = EW'(cell_col_r) + EW'(1) >= wc;
    row_last  = EW'(cell_row_r) + EW'(1) >= hc;
    end_x     = ox_end || row_end;
    end_y     = oy_end || row_last;
    last_cell = row_end && row_last;
    py_full   = EW'(div_q_r) - EW'(blk_row_r);

    s1_nxt.value = $signed(in_tdata);
    s1_nxt.idx   = blk_col_r;
    s1_nxt.first = (off_x_r == '0) && (off_y_r == '0);
    s1_nxt.emit  = end_x && end_y;
    s1_nxt.last  = last_cell;
    s1_nxt.px    = 10'(blk_col_r);
    s1_nxt.py    = py_full[9:0];

    cell_col_nxt = cell_col_r;
    cell_row_nxt = cell_row_r;
    blk_col_nxt  = blk_col_r;
    blk_row_nxt  = blk_row_r;
    off_x_nxt    = off_x_r;
    off_y_nxt    = off_y_r;
    if (row_end) begin
      cell_col_nxt = '0;
      off_x_nxt    = '0;
      blk_col_nxt  = '0;
      if (last_cell) begin
        cell_row_nxt = '0;
        off_y_nxt    = '0;
        blk_row_nxt  = '0;
      end else begin
        cell_row_nxt = cell_row_r + RW'(1);
        if (oy_end) begin
          off_y_nxt   = '0;
          blk_row_nxt = blk_row_r + RW'(1);
        end else begin
          off_y_nxt = off_y_r + OW'(1);
        end
      end
    end else begin
      cell_col_nxt = cell_col_r + CW'(1);
      if (ox_end) begin
        off_x_nxt   = '0;
        blk_col_nxt = blk_col_r + CW'(1);
      end else begin
        off_x_nxt = off_x_r + OW'(1);
      end
    end
  end

  // pooling stage
  always_comb begin
    if (s1_r.first) begin
      prev = -8'sd1;
    end else if (fwd_hit_r) begin
      prev = fwd_data_r;
    end else begin
      prev = ram_rdata;
    end
    pooled = (!s1_r.value[7] && (s1_r.value > prev)) ? s1_r.value : prev;
  end

  ogmc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_GRID_WIDTH)
  ) u_col_max (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.idx),
    .wdata (pooled),
    .re    (in_accept),
    .raddr (blk_col_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= ogmc_pkg::CFG_SIZE_W'(1);
      grid_height_r  <= ogmc_pkg::CFG_SIZE_W'(1);
      decimation_r   <= ogmc_pkg::CFG_DEC_W'(1);
      color_scheme_r <= ogmc_pkg::SCHEME_MAP;
      alpha_level_r  <= ogmc_pkg::ALPHA_RESET;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        ogmc_pkg::REG_GRID_WIDTH:   grid_width_r   <= cfg_data;
        ogmc_pkg::REG_GRID_HEIGHT:  grid_height_r  <= cfg_data;
        ogmc_pkg::REG_DECIMATION:   decimation_r   <= cfg_data[ogmc_pkg::CFG_DEC_W-1:0];
        ogmc_pkg::REG_COLOR_SCHEME: color_scheme_r <= cfg_data[1:0];
        ogmc_pkg::REG_ALPHA_LEVEL:  alpha_level_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // image height - 1 = floor((h - 1) / s), redone after every write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_load_r <= 1'b0;
      div_cnt_r  <= '0;
      div_q_r    <= '0;
      div_rem_r  <= '0;
    end else if (cfg_accept) begin
      div_load_r <= 1'b1;
      div_cnt_r  <= '0;
    end else if (div_load_r) begin
      div_load_r <= 1'b0;
      div_cnt_r  <= ogmc_pkg::DIV_CNT_W'(ogmc_pkg::DIV_STEPS);
      div_q_r    <= hc_m1[QW-1:0];
      div_rem_r  <= '0;
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - ogmc_pkg::DIV_CNT_W'(1);
      div_q_r   <= {div_q_r[QW-2:0], div_bit};
      div_rem_r <= div_bit ? SW'(div_trial - {1'b0, sc}) : div_trial[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_col_r <= '0;
      cell_row_r <= '0;
      blk_col_r  <= '0;
      blk_row_r  <= '0;
      off_x_r    <= '0;
      off_y_r    <= '0;
    end else if (in_accept) begin
      cell_col_r <= cell_col_nxt;
      cell_row_r <= cell_row_nxt;
      blk_col_r  <= blk_col_nxt;
      blk_row_r  <= blk_row_nxt;
      off_x_r    <= off_x_nxt;
      off_y_r    <= off_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
      // bypass the write that lands in the same cycle as this read
      fwd_hit_r  <= s1_adv && (s1_r.idx == blk_col_r);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= pooled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.emit) begin
      out_r.px    <= s1_r.px;
      out_r.py    <= s1_r.py;
      out_r.rgb   <= ogmc_pkg::colorize(pooled, color_scheme_r);
      out_r.alpha <= alpha_level_r;
      out_r.last  <= s1_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.alpha, out_r.rgb.blue, out_r.rgb.green, out_r.rgb.red,
                       out_r.py, out_r.px};
  assign out_tlast  = out_r.last;

endmodule
